// ----- rtl/rrtd_pkg.sv -----
`timescale 1ns / 1ps
package rrtd_pkg;

  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_YIELD   = 3'd2,
    ACT_FORBID  = 3'd3,
    ACT_PERMIT  = 3'd4,
    ACT_DISABLE = 3'd5,
    ACT_ENABLE  = 3'd6
  } action_e;

  localparam int unsigned TaskIds = 16;
  localparam logic signed [7:0] NestMax = 8'sd127;
  localparam logic signed [7:0] NestMin = -8'sd128;
  localparam logic signed [7:0] NestIdle = -8'sd1;

  typedef struct packed {
    logic [2:0]        action;
    logic [3:0]        task_id;
    logic signed [7:0] priority_req;
  } item_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic       switched;
    logic       switch_pending;
    logic       tick_pending;
    logic       queue_full;
    logic [4:0] ready_count;
  } result_t;

  typedef struct packed {
    logic [3:0]        task_id;
    logic signed [7:0] prio;
  } q_ent_t;

  typedef struct packed {
    logic signed [7:0] forbid;
    logic signed [7:0] dis;
  } nest_t;

  function automatic logic signed [7:0] sat_inc(input logic signed [7:0] v);
    return (v == NestMax) ? v : v + 8'sd1;
  endfunction

  function automatic logic signed [7:0] sat_dec(input logic signed [7:0] v);
    return (v == NestMin) ? v : v - 8'sd1;
  endfunction

endpackage

// ----- rtl/rrtd_queue_ram.sv -----
`timescale 1ns / 1ps
module rrtd_queue_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  rrtd_pkg::q_ent_t    wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output rrtd_pkg::q_ent_t    rdata_o
);
  import rrtd_pkg::*;

  q_ent_t mem [DEPTH];
  q_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rrtd_nest_ram.sv -----
`timescale 1ns / 1ps
module rrtd_nest_ram (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           we_i,
  input  logic [3:0]     waddr_i,
  input  rrtd_pkg::nest_t wdata_i,
  input  logic [3:0]     raddr_i,
  output rrtd_pkg::nest_t rdata_o
);
  import rrtd_pkg::*;

  nest_t             mem [TaskIds];
  logic [TaskIds-1:0] valid_q;
  nest_t             rdata_q;
  logic              rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i] || (we_i && waddr_i == raddr_i);
    end
  end

  // write-first: a read of the entry being written returns the new value
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && waddr_i == raddr_i) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  // never-saved tasks read as released counters
  assign rdata_o = rvalid_q ? rdata_q : nest_t'{forbid: NestIdle, dis: NestIdle};

endmodule

// ----- rtl/round_robin_task_dispatcher.sv -----
`timescale 1ns / 1ps
// Task dispatcher with a priority-ordered ready queue and forbid/disable nesting.
// Command channel: a command (action, task_id, priority_req) transfers at a
// rising edge with start high and busy low. One result per command is shown on
// result_o for exactly one cycle with done_o high; the receiver cannot stall it,
// and the next command may transfer in that same cycle.
// Command timing: forbid, disable, an add to a full queue, and tick, yield,
//   permit or enable without a switch: result in the cycle after the
//   transfer, busy stays low, one command per cycle.
//   dispatch (tick, yield, permit or enable that switches): busy through the
//   queue read, then the nest counter memory read-modify-write.
//   add_task: busy for a read and a compare per entry up to the insert point,
//   a read and a write per entry moved toward the tail, then the insert write,
//   set by the single read and write port of the queue.
// Reset clears the queue length, counters and flags at once; the queue memory
// needs no clearing and per-task saved counters read as released until written.
module round_robin_task_dispatcher #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rrtd_pkg::item_t   item_i,
  output logic              done_o,
  output rrtd_pkg::result_t result_o
);
  import rrtd_pkg::*;

  localparam int unsigned QW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned LW = $clog2(MAX_TASKS + 1);
  localparam logic [QW:0]   MaxQ = (QW+1)'(MAX_TASKS);
  localparam logic [LW-1:0] MaxL = LW'(MAX_TASKS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISP     = 3'd1;
  localparam logic [2:0] S_NLD      = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CMP = 3'd4;
  localparam logic [2:0] S_SH_RD    = 3'd5;
  localparam logic [2:0] S_SH_WR    = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [LW-1:0]     len_q, len_d;
  logic [QW-1:0]     head_q, head_d;
  logic [LW-1:0]     idx_q, idx_d;
  logic [LW-1:0]     pos_q, pos_d;
  logic signed [7:0] forbid_q, forbid_d;
  logic signed [7:0] disable_q, disable_d;
  logic              sar_q, sar_d;
  logic              held_q, held_d;
  logic [3:0]        cur_q, cur_d;
  logic              run_q, run_d;
  logic signed [7:0] cprio_q, cprio_d;
  logic [3:0]        id_q, id_d;
  logic signed [7:0] prio_q, prio_d;
  logic              done_q, done_d;
  result_t           res_q, res_d;

  logic          q_we;
  logic [QW-1:0] q_waddr, q_raddr;
  q_ent_t        q_wdata, q_rdata;
  logic          n_we;
  logic [3:0]    n_waddr, n_raddr;
  nest_t         n_wdata, n_rdata;

  logic              accept, fin, sw, full, hnd;
  logic signed [7:0] hf, nest_new;

  // logical queue position to memory address in the circular buffer
  function automatic logic [QW-1:0] phys(input logic [QW-1:0] h, input logic [LW-1:0] l);
    logic [QW:0] s;
    s = {1'b0, h} + (QW+1)'(l);
    if (s >= MaxQ) begin
      s = s - MaxQ;
    end
    return s[QW-1:0];
  endfunction

  rrtd_queue_ram #(.DEPTH(MAX_TASKS), .AW(QW)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  rrtd_nest_ram u_nest (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  assign accept = start && !busy;

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    head_d    = head_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    forbid_d  = forbid_q;
    disable_d = disable_q;
    sar_d     = sar_q;
    held_d    = held_q;
    cur_d     = cur_q;
    run_d     = run_q;
    cprio_d   = cprio_q;
    id_d      = id_q;
    prio_d    = prio_q;
    res_d     = res_q;
    q_we      = 1'b0;
    q_waddr   = phys(head_q, len_q);
    q_wdata   = q_ent_t'{task_id: cur_q, prio: cprio_q};
    q_raddr   = head_q;
    n_we      = 1'b0;
    n_waddr   = cur_q;
    n_wdata   = nest_t'{forbid: forbid_q, dis: disable_q};
    n_raddr   = q_rdata.task_id;
    fin       = 1'b0;
    sw        = 1'b0;
    full      = 1'b0;
    hnd       = 1'b0;
    hf        = forbid_q;
    nest_new  = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          id_d   = item_i.task_id;
          prio_d = item_i.priority_req;
          fin    = 1'b1;
          case (item_i.action)
            ACT_ADD: begin
              if (len_q >= MaxL) begin
                full = 1'b1;
              end else begin
                fin     = 1'b0;
                n_we    = 1'b1;
                n_waddr = item_i.task_id;
                n_wdata = nest_t'{forbid: NestIdle, dis: NestIdle};
                if (len_q == '0) begin
                  idx_d   = '0;
                  pos_d   = '0;
                  state_d = S_SH_RD;
                end else begin
                  idx_d   = '0;
                  state_d = S_SCAN_RD;
                end
              end
            end
            ACT_TICK: begin
              if (!disable_q[7]) begin
                held_d = 1'b1;
              end else begin
                hnd = 1'b1;
              end
            end
            ACT_YIELD: begin
              run_d  = 1'b0;
              held_d = 1'b0;
              hnd    = 1'b1;
            end
            ACT_FORBID: begin
              forbid_d = sat_inc(forbid_q);
            end
            ACT_PERMIT: begin
              nest_new = sat_dec(forbid_q);
              forbid_d = nest_new;
              hf       = nest_new;
              if (nest_new[7] && disable_q[7] && sar_q) begin
                sar_d = 1'b0;
                hnd   = !run_q;
              end
            end
            ACT_DISABLE: begin
              disable_d = sat_inc(disable_q);
            end
            ACT_ENABLE: begin
              nest_new  = sat_dec(disable_q);
              disable_d = nest_new;
              if (nest_new[7] && held_q) begin
                held_d = 1'b0;
                hnd    = 1'b1;
              end
            end
            default: ;
          endcase
          // tick handler: switch now or leave a pending request
          if (hnd) begin
            if (!hf[7]) begin
              sar_d = 1'b1;
            end else if (len_q != '0) begin
              fin     = 1'b0;
              state_d = S_DISP;
            end
          end
        end
      end
      S_DISP: begin
        // head entry is on q_rdata; old task goes to the tail
        q_we    = 1'b1;
        q_waddr = phys(head_q, len_q);
        n_we    = 1'b1;
        n_raddr = q_rdata.task_id;
        cur_d   = q_rdata.task_id;
        cprio_d = q_rdata.prio;
        run_d   = 1'b1;
        head_d  = (head_q == QW'(MAX_TASKS - 1)) ? '0 : head_q + 1'b1;
        state_d = S_NLD;
      end
      S_NLD: begin
        forbid_d  = n_rdata.forbid;
        disable_d = n_rdata.dis;
        sw        = 1'b1;
        fin       = 1'b1;
        state_d   = S_IDLE;
      end
      S_SCAN_RD: begin
        q_raddr = phys(head_q, idx_q);
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (prio_q > q_rdata.prio) begin
          pos_d   = idx_q;
          idx_d   = len_q;
          state_d = S_SH_RD;
        end else if (idx_q + 1'b1 == len_q) begin
          pos_d   = len_q;
          idx_d   = len_q;
          state_d = S_SH_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        if (idx_q == pos_q) begin
          q_we    = 1'b1;
          q_waddr = phys(head_q, idx_q);
          q_wdata = q_ent_t'{task_id: id_q, prio: prio_q};
          len_d   = len_q + 1'b1;
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          q_raddr = phys(head_q, idx_q - 1'b1);
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        q_we    = 1'b1;
        q_waddr = phys(head_q, idx_q);
        q_wdata = q_rdata;
        idx_d   = idx_q - 1'b1;
        state_d = S_SH_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    done_d = fin;
    if (fin) begin
      res_d.running_task   = cur_d;
      res_d.switched       = sw;
      res_d.switch_pending = sar_d;
      res_d.tick_pending   = held_d;
      res_d.queue_full     = full;
      res_d.ready_count    = 5'(len_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      head_q    <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      forbid_q  <= '0;
      disable_q <= '0;
      sar_q     <= 1'b0;
      held_q    <= 1'b0;
      cur_q     <= '0;
      run_q     <= 1'b0;
      cprio_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      head_q    <= head_d;
      idx_q     <= idx_d;
      pos_q     <= pos_d;
      forbid_q  <= forbid_d;
      disable_q <= disable_d;
      sar_q     <= sar_d;
      held_q    <= held_d;
      cur_q     <= cur_d;
      run_q     <= run_d;
      cprio_q   <= cprio_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
    res_q  <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- rtl/rrtd_checker.sv -----
`timescale 1ns / 1ps
module rrtd_checker #(
  parameter int unsigned MAX_TASKS = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input rrtd_pkg::item_t   item_i,
  input logic              done_o,
  input rrtd_pkg::result_t result_o
);
  import rrtd_pkg::*;

  // a result only appears once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // every transfer either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("command transfer lost");

  // no result without a command in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !done_o)
    else $error("result without command");

  // a full report only when the queue holds its maximum
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.queue_full) |-> result_o.ready_count == 5'(MAX_TASKS))
    else $error("queue full with wrong count");

  // a full queue report only comes from an add
  a_full_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.action != ACT_ADD) |=> !(done_o && result_o.queue_full))
    else $error("queue full on non-add command");

endmodule

bind round_robin_task_dispatcher rrtd_checker #(.MAX_TASKS(MAX_TASKS)) u_rrtd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);
